@@ rtl/ngram_block_signature_builder_macros.svh @@
// assertion helpers for the rtl files, included by nbsb_ctrl
`ifndef NGRAM_BLOCK_SIGNATURE_BUILDER_MACROS_SVH
`define NGRAM_BLOCK_SIGNATURE_BUILDER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define NBSB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define NBSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/nbsb_pkg.sv @@
`timescale 1ns / 1ps
package nbsb_pkg;

  localparam logic [1:0] OP_TEXT    = 2'd0;
  localparam logic [1:0] OP_END     = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_RELEASE = 2'd3;

  localparam logic LEVEL_FINE   = 1'b0;
  localparam logic LEVEL_COARSE = 1'b1;

  localparam int SIG_WORDS = 2052;
  localparam int ADDR_BITS = 12;
  localparam logic [ADDR_BITS-1:0] BIGRAM_BASE  = 12'd4;
  localparam logic [ADDR_BITS-1:0] TRIGRAM_BASE = 12'd1028;
  localparam logic [ADDR_BITS-1:0] LAST_WORD    = 12'd2051;

  localparam logic [31:0] MIX_C1 = 32'h7feb352d;
  localparam logic [31:0] MIX_C2 = 32'h846ca68b;

  localparam logic CFG_BLOCK       = 1'b0;
  localparam logic CFG_SUPER_BLOCK = 1'b1;

  // which bit of the byte's update is being set
  localparam logic [1:0] BIT_BYTE  = 2'd0;
  localparam logic [1:0] BIT_BIGRAM = 2'd1;
  localparam logic [1:0] BIT_TRI_LO = 2'd2;
  localparam logic [1:0] BIT_TRI_HI = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  text_byte;
    logic        last_package;
    logic        level;
    logic [11:0] word_index;
  } item_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        status;
    logic        fine_done;
    logic        coarse_done;
    logic [31:0] fine_first;
    logic [15:0] fine_count;
    logic [31:0] coarse_first;
    logic [15:0] coarse_count;
  } result_t;

  typedef struct packed {
    logic       accept;
    logic       hash1;
    logic       hash2;
    logic       ram_rd;
    logic       ram_wr;
    logic [1:0] bit_sel;
    logic       clr_fine;
    logic       clr_coarse;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic       fine_held;
    logic       coarse_held;
    logic [1:0] bytes_seen;
    logic       clr_last;
  } stat_t;

endpackage

@@ rtl/ngram_block_signature_builder.sv @@
`timescale 1ns / 1ps
// text byte: trigram hash, then a read and a write per map bit set (1, 2 or 4 bits),
//   paced by the read-modify-write on the single-port signature memories
// end of package or rejected word: no memory step; read: one read; release: clears the held level
// reset: clearing pass over all 2052 words of both signature memories, busy stays high until done
// one word at a time, busy drops as the result shows
// each result shows for one cycle on result_valid, here the receiver cannot stall
module ngram_block_signature_builder #(
  parameter int PACKAGE_INDEX_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  nbsb_pkg::item_t   item,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output nbsb_pkg::result_t result,
  output logic              result_valid
);

  nbsb_pkg::cmd_t  cmd;
  nbsb_pkg::stat_t stat;

  // sequencer
  nbsb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (item.opcode),
    .level  (item.level),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // signature memories, hash and block accounting
  nbsb_datapath #(.PACKAGE_INDEX_BITS(PACKAGE_INDEX_BITS)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

@@ rtl/nbsb_ram.sv @@
`timescale 1ns / 1ps
module nbsb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2052
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/nbsb_datapath.sv @@
`timescale 1ns / 1ps
module nbsb_datapath #(
  parameter int PACKAGE_INDEX_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  nbsb_pkg::item_t item,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  input  nbsb_pkg::cmd_t  cmd,
  output nbsb_pkg::stat_t stat,
  output nbsb_pkg::result_t result,
  output logic            result_valid
);

  nbsb_pkg::item_t item_q;
  logic [15:0] block_packages;
  logic [15:0] super_block_packages;
  logic [7:0]  older_byte;
  logic [7:0]  newer_byte;
  logic [1:0]  bytes_seen;
  logic [15:0] fine_total;
  logic [15:0] coarse_total;
  logic [PACKAGE_INDEX_BITS-1:0] fine_start;
  logic [PACKAGE_INDEX_BITS-1:0] coarse_start;
  logic [PACKAGE_INDEX_BITS-1:0] package_counter;
  logic fine_held;
  logic coarse_held;
  logic [31:0] mix1;
  logic [31:0] mix2;
  logic [11:0] clr_addr;

  logic [31:0] tri_word;
  logic [31:0] v1;
  logic [31:0] v2;
  logic [31:0] hash;
  logic [11:0] bit_word;
  logic [5:0]  bit_pos;
  logic [63:0] bit_mask;
  logic [11:0] ram_addr;
  logic        read_in_range;
  logic [63:0] fine_rdata;
  logic [63:0] coarse_rdata;
  logic        coarse_on;
  logic        held;
  logic        we_fine;
  logic        we_coarse;
  logic [63:0] wdata_fine;
  logic [63:0] wdata_coarse;
  logic [15:0] flimit;
  logic [15:0] ftot_inc;
  logic [15:0] ctot_inc;
  logic [PACKAGE_INDEX_BITS-1:0] fstart_new;
  logic [PACKAGE_INDEX_BITS-1:0] cstart_new;
  logic        fdone;
  logic        cdone;
  nbsb_pkg::result_t res_next;

  assign coarse_on = super_block_packages != 16'd0;
  assign held      = fine_held | coarse_held;

  assign stat.fine_held   = fine_held;
  assign stat.coarse_held = coarse_held;
  assign stat.bytes_seen  = bytes_seen;
  assign stat.clr_last    = clr_addr == nbsb_pkg::LAST_WORD;

  // lowbias hash of the trigram, one multiply per cycle
  assign tri_word = {8'd0, older_byte, newer_byte, item_q.text_byte};
  assign v1       = tri_word ^ (tri_word >> 16);
  assign v2       = mix1 ^ (mix1 >> 15);
  assign hash     = mix2 ^ (mix2 >> 16);

  always_ff @(posedge clk) begin
    if (cmd.hash1) begin
      mix1 <= v1 * nbsb_pkg::MIX_C1;
    end
    if (cmd.hash2) begin
      mix2 <= v2 * nbsb_pkg::MIX_C2;
    end
  end

  // word and bit of the map bit being set
  always_comb begin
    case (cmd.bit_sel)
      nbsb_pkg::BIT_BYTE: begin
        bit_word = {10'd0, item_q.text_byte[7:6]};
        bit_pos  = item_q.text_byte[5:0];
      end
      nbsb_pkg::BIT_BIGRAM: begin
        bit_word = nbsb_pkg::BIGRAM_BASE + {2'd0, newer_byte, item_q.text_byte[7:6]};
        bit_pos  = item_q.text_byte[5:0];
      end
      nbsb_pkg::BIT_TRI_LO: begin
        bit_word = nbsb_pkg::TRIGRAM_BASE + {2'd0, hash[15:6]};
        bit_pos  = hash[5:0];
      end
      default: begin
        bit_word = nbsb_pkg::TRIGRAM_BASE + {2'd0, hash[31:22]};
        bit_pos  = hash[21:16];
      end
    endcase
  end

  assign bit_mask      = 64'd1 << bit_pos;
  assign read_in_range = item_q.word_index < 12'(nbsb_pkg::SIG_WORDS);

  // memory address select
  always_comb begin
    if (cmd.clr_fine || cmd.clr_coarse) begin
      ram_addr = clr_addr;
    end else if (item_q.opcode == nbsb_pkg::OP_READ) begin
      ram_addr = read_in_range ? item_q.word_index : 12'd0;
    end else begin
      ram_addr = bit_word;
    end
  end

  assign we_fine      = cmd.clr_fine | cmd.ram_wr;
  assign we_coarse    = cmd.clr_coarse | (cmd.ram_wr & coarse_on);
  assign wdata_fine   = cmd.clr_fine ? 64'd0 : (fine_rdata | bit_mask);
  assign wdata_coarse = cmd.clr_coarse ? 64'd0 : (coarse_rdata | bit_mask);

  nbsb_ram #(.WIDTH(64), .DEPTH(nbsb_pkg::SIG_WORDS)) u_fine_ram (
    .clk   (clk),
    .we    (we_fine),
    .addr  (ram_addr),
    .wdata (wdata_fine),
    .rdata (fine_rdata)
  );

  nbsb_ram #(.WIDTH(64), .DEPTH(nbsb_pkg::SIG_WORDS)) u_coarse_ram (
    .clk   (clk),
    .we    (we_coarse),
    .addr  (ram_addr),
    .wdata (wdata_coarse),
    .rdata (coarse_rdata)
  );

  // block accounting for end of package
  assign flimit     = (block_packages == 16'd0) ? 16'd1 : block_packages;
  assign ftot_inc   = fine_total + 16'd1;
  assign ctot_inc   = coarse_total + 16'd1;
  assign fstart_new = (fine_total == 16'd0) ? package_counter : fine_start;
  assign cstart_new = (coarse_total == 16'd0) ? package_counter : coarse_start;
  assign fdone      = (ftot_inc == flimit) | item_q.last_package;
  assign cdone      = coarse_on & ((ctot_inc == super_block_packages) | item_q.last_package);

  // result word
  always_comb begin
    res_next = '0;
    case (item_q.opcode)
      nbsb_pkg::OP_TEXT: begin
        res_next.status = held;
      end
      nbsb_pkg::OP_END: begin
        res_next.status = held;
        if (!held) begin
          res_next.fine_done   = fdone;
          res_next.coarse_done = cdone;
          if (fdone) begin
            res_next.fine_first = 32'(fstart_new);
            res_next.fine_count = ftot_inc;
          end
          if (cdone) begin
            res_next.coarse_first = 32'(cstart_new);
            res_next.coarse_count = ctot_inc;
          end
        end
      end
      nbsb_pkg::OP_READ: begin
        if (read_in_range) begin
          res_next.read_data = (item_q.level == nbsb_pkg::LEVEL_COARSE) ?
                               coarse_rdata : fine_rdata;
        end
      end
      default: begin
        res_next.status = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_q <= item;
    end
    if (cmd.finish) begin
      result <= res_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      block_packages       <= 16'd1;
      super_block_packages <= 16'd0;
      older_byte           <= 8'd0;
      newer_byte           <= 8'd0;
      bytes_seen           <= 2'd0;
      fine_total           <= 16'd0;
      coarse_total         <= 16'd0;
      fine_start           <= '0;
      coarse_start         <= '0;
      package_counter      <= '0;
      fine_held            <= 1'b0;
      coarse_held          <= 1'b0;
      clr_addr             <= 12'd0;
      result_valid         <= 1'b0;
    end else begin
      result_valid <= cmd.finish;
      if (cfg_we) begin
        if (cfg_index == nbsb_pkg::CFG_BLOCK) begin
          block_packages <= cfg_data;
        end else begin
          super_block_packages <= cfg_data;
        end
      end
      if (cmd.clr_fine || cmd.clr_coarse) begin
        clr_addr <= stat.clr_last ? 12'd0 : clr_addr + 12'd1;
      end
      if (cmd.finish) begin
        case (item_q.opcode)
          nbsb_pkg::OP_TEXT: begin
            if (!held) begin
              older_byte <= newer_byte;
              newer_byte <= item_q.text_byte;
              if (bytes_seen != 2'd2) begin
                bytes_seen <= bytes_seen + 2'd1;
              end
            end
          end
          nbsb_pkg::OP_END: begin
            if (!held) begin
              fine_total <= ftot_inc;
              fine_start <= fstart_new;
              fine_held  <= fdone;
              if (coarse_on) begin
                coarse_total <= ctot_inc;
                coarse_start <= cstart_new;
                coarse_held  <= cdone;
              end
              package_counter <= item_q.last_package ? '0 :
                                 package_counter + PACKAGE_INDEX_BITS'(1);
              older_byte <= 8'd0;
              newer_byte <= 8'd0;
              bytes_seen <= 2'd0;
            end
          end
          nbsb_pkg::OP_RELEASE: begin
            if (item_q.level == nbsb_pkg::LEVEL_FINE) begin
              if (fine_held) begin
                fine_total <= 16'd0;
                fine_held  <= 1'b0;
              end
            end else if (coarse_held) begin
              coarse_total <= 16'd0;
              coarse_held  <= 1'b0;
            end
          end
          default: begin
            fine_held <= fine_held;
          end
        endcase
      end
    end
  end

endmodule

@@ rtl/nbsb_ctrl.sv @@
`timescale 1ns / 1ps
`include "ngram_block_signature_builder_macros.svh"
module nbsb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      opcode,
  input  logic            level,
  input  nbsb_pkg::stat_t stat,
  output nbsb_pkg::cmd_t  cmd,
  output logic            busy
);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_H1   = 4'd2;
  localparam logic [3:0] S_H2   = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_WR   = 4'd5;
  localparam logic [3:0] S_MRD  = 4'd6;
  localparam logic [3:0] S_CLR  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] bit_sel;
  logic [1:0] bit_sel_next;
  logic       clr_level;
  logic       clr_level_next;
  logic       held;
  logic       more_bits;
  logic       accept;

  assign held   = stat.fine_held | stat.coarse_held;
  assign busy   = state != S_IDLE;
  assign accept = start & !busy;

  // another map bit to set for this byte
  assign more_bits = ((bit_sel == nbsb_pkg::BIT_BYTE) && (stat.bytes_seen != 2'd0)) ||
                     ((bit_sel == nbsb_pkg::BIT_BIGRAM) && (stat.bytes_seen == 2'd2)) ||
                     (bit_sel == nbsb_pkg::BIT_TRI_LO);

  always_comb begin
    state_next     = state;
    bit_sel_next   = bit_sel;
    clr_level_next = clr_level;
    cmd            = '0;
    cmd.bit_sel    = bit_sel;
    case (state)
      S_INIT: begin
        cmd.clr_fine   = 1'b1;
        cmd.clr_coarse = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept   = 1'b1;
          bit_sel_next = nbsb_pkg::BIT_BYTE;
          case (opcode)
            nbsb_pkg::OP_TEXT: begin
              state_next = held ? S_FIN : S_H1;
            end
            nbsb_pkg::OP_READ: begin
              state_next = S_MRD;
            end
            nbsb_pkg::OP_RELEASE: begin
              clr_level_next = level;
              if ((level == nbsb_pkg::LEVEL_FINE) ? stat.fine_held : stat.coarse_held) begin
                state_next = S_CLR;
              end else begin
                state_next = S_FIN;
              end
            end
            default: begin
              state_next = S_FIN;
            end
          endcase
        end
      end
      S_H1: begin
        cmd.hash1  = 1'b1;
        state_next = S_H2;
      end
      S_H2: begin
        cmd.hash2  = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.ram_rd = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.ram_wr = 1'b1;
        if (more_bits) begin
          bit_sel_next = bit_sel + 2'd1;
          state_next   = S_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_MRD: begin
        cmd.ram_rd = 1'b1;
        state_next = S_FIN;
      end
      S_CLR: begin
        cmd.clr_fine   = clr_level == nbsb_pkg::LEVEL_FINE;
        cmd.clr_coarse = clr_level == nbsb_pkg::LEVEL_COARSE;
        if (stat.clr_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      bit_sel   <= nbsb_pkg::BIT_BYTE;
      clr_level <= nbsb_pkg::LEVEL_FINE;
    end else begin
      state     <= state_next;
      bit_sel   <= bit_sel_next;
      clr_level <= clr_level_next;
    end
  end

  `NBSB_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "accepted word did not raise busy")
  `NBSB_ASSERT_IMP(a_wr_after_rd, clk, rst, state == S_WR, $past(state) == S_RD, "write without read")
  `NBSB_ASSERT_NEXT(a_fin_to_idle, clk, rst, state == S_FIN, state == S_IDLE, "finish not followed by idle")
  `NBSB_ASSERT_IMP(a_one_cmd, clk, rst, 1'b1, $onehot0({cmd.ram_rd, cmd.ram_wr, cmd.finish, cmd.hash1, cmd.hash2}), "conflicting commands")

endmodule

@@ bench/ngram_block_signature_builder_tb.sv @@
`timescale 1ns / 1ps
module ngram_block_signature_builder_tb;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  nbsb_pkg::item_t   item = '0;
  logic    cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  nbsb_pkg::result_t result;
  logic    result_valid;

  ngram_block_signature_builder dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result(result), .result_valid(result_valid)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the signature builder
  logic [63:0] sig_mem [2][nbsb_pkg::SIG_WORDS];
  logic [7:0]  prev2_byte, prev1_byte;
  logic [1:0]  run_len;
  logic [15:0] pkg_total [2];
  logic [31:0] first_pkg [2];
  logic [31:0] pkg_index;
  logic        level_held [2];
  logic [15:0] block_size, super_size;

  // recently set words, used to aim reads at nonzero data
  logic [11:0] hot_words [64];
  int          hot_ptr;

  nbsb_pkg::result_t expected_q[$];
  int  fail_count;
  int  item_total, read_total, done_total, reject_total;
  bit  gaps_on;

  function automatic logic [31:0] lowbias_mix(logic [31:0] v);
    v = v ^ (v >> 16);
    v = v * nbsb_pkg::MIX_C1;
    v = v ^ (v >> 15);
    v = v * nbsb_pkg::MIX_C2;
    v = v ^ (v >> 16);
    return v;
  endfunction

  function automatic void mark_bit(int lvl, int base, logic [15:0] bitpos);
    int w;
    w = base + int'(bitpos >> 6);
    sig_mem[lvl][w][bitpos[5:0]] = 1'b1;
    hot_words[hot_ptr] = w[11:0];
    hot_ptr = (hot_ptr + 1) % 64;
  endfunction

  function automatic void add_text(int lvl, logic [7:0] b);
    logic [31:0] h;
    mark_bit(lvl, 0, {8'd0, b});
    if (run_len >= 2'd1) mark_bit(lvl, int'(nbsb_pkg::BIGRAM_BASE), {prev1_byte, b});
    if (run_len >= 2'd2) begin
      h = lowbias_mix({8'd0, prev2_byte, prev1_byte, b});
      mark_bit(lvl, int'(nbsb_pkg::TRIGRAM_BASE), h[15:0]);
      mark_bit(lvl, int'(nbsb_pkg::TRIGRAM_BASE), h[31:16]);
    end
  endfunction

  function automatic void clear_level(int lvl);
    for (int i = 0; i < nbsb_pkg::SIG_WORDS; i++) sig_mem[lvl][i] = '0;
    pkg_total[lvl] = '0;
    level_held[lvl] = 1'b0;
  endfunction

  function automatic void reset_shadow();
    clear_level(0);
    clear_level(1);
    first_pkg[0] = '0;
    first_pkg[1] = '0;
    prev2_byte = '0;
    prev1_byte = '0;
    run_len = '0;
    pkg_index = '0;
    block_size = 16'd1;
    super_size = 16'd0;
    hot_ptr = 0;
    for (int i = 0; i < 64; i++) hot_words[i] = '0;
  endfunction

  // expected result of one word, updating the shadow state
  function automatic nbsb_pkg::result_t apply_word(nbsb_pkg::item_t w);
    nbsb_pkg::result_t r;
    logic held, coarse_on;
    logic [15:0] flimit;
    r = '0;
    held = level_held[0] | level_held[1];
    coarse_on = (super_size != 16'd0);
    case (w.opcode)
      nbsb_pkg::OP_TEXT: begin
        if (held) begin
          r.status = 1'b1;
        end else begin
          add_text(0, w.text_byte);
          if (coarse_on) add_text(1, w.text_byte);
          prev2_byte = prev1_byte;
          prev1_byte = w.text_byte;
          if (run_len < 2'd2) run_len = run_len + 2'd1;
        end
      end
      nbsb_pkg::OP_END: begin
        if (held) begin
          r.status = 1'b1;
        end else begin
          flimit = (block_size != 16'd0) ? block_size : 16'd1;
          if (pkg_total[0] == 16'd0) first_pkg[0] = pkg_index;
          pkg_total[0] = pkg_total[0] + 16'd1;
          if (pkg_total[0] == flimit || w.last_package) begin
            level_held[0] = 1'b1;
            r.fine_done = 1'b1;
            r.fine_first = first_pkg[0];
            r.fine_count = pkg_total[0];
          end
          if (coarse_on) begin
            if (pkg_total[1] == 16'd0) first_pkg[1] = pkg_index;
            pkg_total[1] = pkg_total[1] + 16'd1;
            if (pkg_total[1] == super_size || w.last_package) begin
              level_held[1] = 1'b1;
              r.coarse_done = 1'b1;
              r.coarse_first = first_pkg[1];
              r.coarse_count = pkg_total[1];
            end
          end
          pkg_index = w.last_package ? 32'd0 : pkg_index + 32'd1;
          prev2_byte = '0;
          prev1_byte = '0;
          run_len = '0;
        end
      end
      nbsb_pkg::OP_READ: begin
        if (w.word_index <= nbsb_pkg::LAST_WORD) begin
          r.read_data = sig_mem[w.level][w.word_index];
        end
      end
      default: begin
        if (level_held[w.level]) clear_level(int'(w.level));
      end
    endcase
    return r;
  endfunction

  function automatic nbsb_pkg::item_t make_word(logic [1:0] op, logic [7:0] b, logic lastp,
                                                logic lvl, logic [11:0] idx);
    nbsb_pkg::item_t w;
    w.opcode = op;
    w.text_byte = b;
    w.last_package = lastp;
    w.level = lvl;
    w.word_index = idx;
    return w;
  endfunction

  // check each result against the oldest expectation
  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    nbsb_pkg::result_t e;
    if (!rst && result_valid) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, result);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        check_field("read_data", e.read_data, result.read_data);
        check_field("status", 64'(e.status), 64'(result.status));
        check_field("fine_done", 64'(e.fine_done), 64'(result.fine_done));
        check_field("coarse_done", 64'(e.coarse_done), 64'(result.coarse_done));
        check_field("fine_first", 64'(e.fine_first), 64'(result.fine_first));
        check_field("fine_count", 64'(e.fine_count), 64'(result.fine_count));
        check_field("coarse_first", 64'(e.coarse_first), 64'(result.coarse_first));
        check_field("coarse_count", 64'(e.coarse_count), 64'(result.coarse_count));
      end
    end
  end

  // send one word and record its expected result
  task automatic send_word(nbsb_pkg::item_t w);
    nbsb_pkg::result_t r;
    @(negedge clk);
    start <= 1'b1;
    item <= w;
    // busy only moves at the rising edge, so its value here holds through the next one
    while (busy) @(negedge clk);
    @(posedge clk);
    r = apply_word(w);
    expected_q = {expected_q, r};
    item_total++;
    if (w.opcode == nbsb_pkg::OP_READ) read_total++;
    if (r.fine_done || r.coarse_done) done_total++;
    if (r.status) reject_total++;
    @(negedge clk);
    start <= 1'b0;
    if (gaps_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 11)) @(negedge clk);
  endtask

  task automatic wait_drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    wait_drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == nbsb_pkg::CFG_BLOCK) block_size = val;
    else super_size = val;
  endtask

  function automatic logic [11:0] pick_index();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return hot_words[$urandom_range(0, 63)];
    if (sel < 9) return 12'($urandom_range(0, nbsb_pkg::SIG_WORDS - 1));
    return 12'($urandom_range(0, 4095));
  endfunction

  task automatic read_some(int n);
    for (int i = 0; i < n; i++)
      send_word(make_word(nbsb_pkg::OP_READ, 8'($urandom), 1'($urandom), 1'($urandom),
                          pick_index()));
  endtask

  // mostly well-formed packages, read back and release held levels, some noise
  task automatic run_traffic(int n_items);
    int stop_at, sel;
    logic [7:0] alpha;
    stop_at = item_total + n_items;
    alpha = 8'($urandom_range(1, 7));
    while (item_total < stop_at) begin
      if (level_held[0] || level_held[1]) begin
        read_some($urandom_range(1, 4));
        if ($urandom_range(0, 3) == 0)
          send_word(make_word(1'($urandom) ? nbsb_pkg::OP_TEXT : nbsb_pkg::OP_END,
                              8'($urandom), 1'($urandom), 1'($urandom), 12'($urandom)));
        if ($urandom_range(0, 4) == 0)
          send_word(make_word(nbsb_pkg::OP_RELEASE, 8'($urandom), 1'($urandom),
                              1'($urandom), 12'($urandom)));
        if (level_held[0])
          send_word(make_word(nbsb_pkg::OP_RELEASE, '0, 1'b0, nbsb_pkg::LEVEL_FINE, '0));
        if (level_held[1])
          send_word(make_word(nbsb_pkg::OP_RELEASE, '0, 1'b0, nbsb_pkg::LEVEL_COARSE, '0));
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 82) begin
          // small alphabet repeats n-grams, the full range hits every byte bit
          if ($urandom_range(0, 1))
            send_word(make_word(nbsb_pkg::OP_TEXT,
                                8'($urandom_range('h61, 'h61 + int'(alpha))),
                                1'($urandom), 1'($urandom), 12'($urandom)));
          else
            send_word(make_word(nbsb_pkg::OP_TEXT, 8'($urandom), 1'($urandom),
                                1'($urandom), 12'($urandom)));
        end else if (sel < 94) begin
          send_word(make_word(nbsb_pkg::OP_END, 8'($urandom), $urandom_range(0, 7) == 0,
                              1'($urandom), 12'($urandom)));
        end else begin
          read_some(1);
        end
      end
    end
  endtask

  task automatic test_directed();
    send_word(make_word(nbsb_pkg::OP_TEXT, 8'h00, 1'b0, 1'b0, '0));
    send_word(make_word(nbsb_pkg::OP_TEXT, 8'hff, 1'b0, 1'b0, '0));
    send_word(make_word(nbsb_pkg::OP_TEXT, 8'h00, 1'b1, 1'b1, 12'hfff));
    send_word(make_word(nbsb_pkg::OP_TEXT, 8'hff, 1'b0, 1'b0, '0));
    // block of one package completes at once
    send_word(make_word(nbsb_pkg::OP_END, '0, 1'b0, 1'b0, '0));
    // held level rejects text and end of package
    send_word(make_word(nbsb_pkg::OP_TEXT, 8'h5a, 1'b0, 1'b0, '0));
    send_word(make_word(nbsb_pkg::OP_END, '0, 1'b1, 1'b0, '0));
    send_word(make_word(nbsb_pkg::OP_READ, '0, 1'b0, nbsb_pkg::LEVEL_FINE, 12'd0));
    send_word(make_word(nbsb_pkg::OP_READ, '0, 1'b0, nbsb_pkg::LEVEL_FINE, 12'd3));
    send_word(make_word(nbsb_pkg::OP_READ, '0, 1'b0, nbsb_pkg::LEVEL_FINE,
                        hot_words[(hot_ptr + 63) % 64]));
    send_word(make_word(nbsb_pkg::OP_READ, '0, 1'b0, nbsb_pkg::LEVEL_FINE,
                        nbsb_pkg::LAST_WORD));
    send_word(make_word(nbsb_pkg::OP_READ, '0, 1'b0, nbsb_pkg::LEVEL_FINE,
                        nbsb_pkg::LAST_WORD + 12'd1));
    send_word(make_word(nbsb_pkg::OP_READ, '0, 1'b0, nbsb_pkg::LEVEL_FINE, 12'hfff));
    send_word(make_word(nbsb_pkg::OP_READ, '0, 1'b0, nbsb_pkg::LEVEL_COARSE, 12'd0));
    // release of a level that is not held does nothing, then the held fine level is released
    send_word(make_word(nbsb_pkg::OP_RELEASE, '0, 1'b0, nbsb_pkg::LEVEL_COARSE, '0));
    send_word(make_word(nbsb_pkg::OP_RELEASE, '0, 1'b0, nbsb_pkg::LEVEL_FINE, '0));
    send_word(make_word(nbsb_pkg::OP_READ, '0, 1'b0, nbsb_pkg::LEVEL_FINE, 12'd0));
  endtask

  // zero block size acts as one, last package restarts the index
  task automatic test_zero_block_and_last();
    write_reg(nbsb_pkg::CFG_BLOCK, 16'd0);
    send_word(make_word(nbsb_pkg::OP_TEXT, 8'h41, 1'b0, 1'b0, '0));
    send_word(make_word(nbsb_pkg::OP_END, '0, 1'b1, 1'b0, '0));
    send_word(make_word(nbsb_pkg::OP_RELEASE, '0, 1'b0, nbsb_pkg::LEVEL_FINE, '0));
    send_word(make_word(nbsb_pkg::OP_END, '0, 1'b0, 1'b0, '0));
    send_word(make_word(nbsb_pkg::OP_RELEASE, '0, 1'b0, nbsb_pkg::LEVEL_FINE, '0));
  endtask

  // coarse level stays held after it is disabled
  task automatic test_coarse_disable_while_held();
    write_reg(nbsb_pkg::CFG_BLOCK, 16'd1);
    write_reg(nbsb_pkg::CFG_SUPER_BLOCK, 16'd2);
    send_word(make_word(nbsb_pkg::OP_TEXT, 8'h10, 1'b0, 1'b0, '0));
    send_word(make_word(nbsb_pkg::OP_TEXT, 8'h20, 1'b0, 1'b0, '0));
    send_word(make_word(nbsb_pkg::OP_TEXT, 8'h30, 1'b0, 1'b0, '0));
    send_word(make_word(nbsb_pkg::OP_END, '0, 1'b0, 1'b0, '0));
    send_word(make_word(nbsb_pkg::OP_RELEASE, '0, 1'b0, nbsb_pkg::LEVEL_FINE, '0));
    send_word(make_word(nbsb_pkg::OP_END, '0, 1'b0, 1'b0, '0));
    read_some(3);
    send_word(make_word(nbsb_pkg::OP_RELEASE, '0, 1'b0, nbsb_pkg::LEVEL_FINE, '0));
    write_reg(nbsb_pkg::CFG_SUPER_BLOCK, 16'd0);
    send_word(make_word(nbsb_pkg::OP_TEXT, 8'h40, 1'b0, 1'b0, '0));
    send_word(make_word(nbsb_pkg::OP_READ, '0, 1'b0, nbsb_pkg::LEVEL_COARSE,
                        hot_words[(hot_ptr + 63) % 64]));
    send_word(make_word(nbsb_pkg::OP_RELEASE, '0, 1'b0, nbsb_pkg::LEVEL_COARSE, '0));
    send_word(make_word(nbsb_pkg::OP_READ, '0, 1'b0, nbsb_pkg::LEVEL_COARSE, 12'd0));
  endtask

  task automatic test_config_sweep();
    write_reg(nbsb_pkg::CFG_BLOCK, 16'd3);
    write_reg(nbsb_pkg::CFG_SUPER_BLOCK, 16'd1);
    run_traffic(150);
    write_reg(nbsb_pkg::CFG_BLOCK, 16'd2);
    write_reg(nbsb_pkg::CFG_SUPER_BLOCK, 16'd5);
    run_traffic(150);
    // a sender pause until everything has drained
    wait_drain();
    write_reg(nbsb_pkg::CFG_BLOCK, 16'hffff);
    write_reg(nbsb_pkg::CFG_SUPER_BLOCK, 16'hffff);
    run_traffic(150);
    write_reg(nbsb_pkg::CFG_BLOCK, 16'd4);
    write_reg(nbsb_pkg::CFG_SUPER_BLOCK, 16'd0);
    run_traffic(150);
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    write_reg(nbsb_pkg::CFG_BLOCK, 16'd2);
    write_reg(nbsb_pkg::CFG_SUPER_BLOCK, 16'd3);
    run_traffic(150);
  endtask

  initial begin
    int waited;
    fail_count = 0;
    item_total = 0;
    read_total = 0;
    done_total = 0;
    reject_total = 0;
    gaps_on = 1'b1;
    reset_shadow();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_zero_block_and_last();
    test_coarse_disable_while_held();
    test_config_sweep();
    test_back_to_back();
    waited = 0;
    while (expected_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (expected_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_q.size());
      fail_count++;
    end
    $display("covered %0d words: %0d reads, %0d completed blocks, %0d rejected",
             item_total, read_total, done_total, reject_total);
    $display("block sizes swept from zero to 65535, coarse level on and off");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
